### rtl/core/lfpp_pkg.sv
// Shared types, codes and the CRC-8 update for the length-framed packet parser.
package lfpp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned StatusW = 2;

  localparam logic [ByteW-1:0] HEADER_RESET = 8'hAA;
  localparam logic [ByteW-1:0] CRC_POLY = 8'h07;

  localparam logic [StatusW-1:0] STATUS_NONE = 2'd0;
  localparam logic [StatusW-1:0] STATUS_GOOD = 2'd1;
  localparam logic [StatusW-1:0] STATUS_CRC_ERR = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_LEN     = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CRC     = 4'b1000
  } phase_t;

  // One byte through CRC-8, MSB first, no reflection, no final xor.
  function automatic logic [ByteW-1:0] crc8_step(input logic [ByteW-1:0] acc,
                                                input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = acc ^ b;
    for (int k = 0; k < ByteW; k++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/length_framed_packet_parser_crc8.sv
// Top level of the length-framed packet parser with CRC-8 check.
//
// The parser takes one received byte per item and returns exactly one result
// item for it. While idle it waits for a byte equal to the header register;
// the byte after the header is the frame length, then that many payload bytes
// follow, then one CRC byte. The CRC is CRC-8 (polynomial 0x07, initial value
// zero, MSB first, no final xor) over the length byte and the payload bytes.
// Each payload byte is streamed out with its index and a last marker, and the
// CRC byte ends the frame with status good or CRC error, after which the
// parser goes back to idle. A header value seen inside a frame is an ordinary
// byte. The phase logic and the unrolled CRC update sit between the input
// handshake and a single result register, so one item is accepted in every
// cycle as long as the result side keeps taking items.
// The input is stalled only while the result register holds an item that the
// result side is stalling. The header register may be written through
// header_we and header_wdata while no item is in flight, even in the middle
// of a frame; a new value applies from the next idle comparison on.
module length_framed_packet_parser_crc8
  import lfpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Configuration write port for the header register.
  input  logic               header_we,
  input  logic [ByteW-1:0]   header_wdata,
  // Input channel.
  input  logic               data_valid,
  output logic               data_stall,
  input  logic [ByteW-1:0]   data_byte,
  // Result channel.
  output logic               result_valid,
  input  logic               result_stall,
  output logic [StatusW-1:0] status,
  output logic               payload_valid,
  output logic [ByteW-1:0]   payload_byte,
  output logic [ByteW-1:0]   payload_index,
  output logic               payload_last
);

  logic [ByteW-1:0] header_value;

  phase_t           phase;
  phase_t           phase_next;
  logic [ByteW-1:0] crc_value;
  logic [ByteW-1:0] crc_value_next;
  logic [ByteW-1:0] frame_length;
  logic [ByteW-1:0] frame_length_next;
  logic [ByteW-1:0] bytes_seen;
  logic [ByteW-1:0] bytes_seen_next;

  logic [StatusW-1:0] status_next;
  logic               payload_valid_next;
  logic [ByteW-1:0]   payload_byte_next;
  logic [ByteW-1:0]   payload_index_next;
  logic               payload_last_next;

  logic [ByteW-1:0] crc_upd;
  logic [ByteW-1:0] seen_inc;
  logic             accept;

  // The result register can take a new item when it is empty or when its
  // current item leaves at this edge.
  assign data_stall = result_valid && result_stall;
  assign accept     = data_valid && !data_stall;

  assign crc_upd  = crc8_step(crc_value, data_byte);
  assign seen_inc = bytes_seen + 1'b1;

  // Header register: written at any edge with the write enable high.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= HEADER_RESET;
    end else if (header_we) begin
      header_value <= header_wdata;
    end
  end

  // Phase logic and the result fields for the byte on the input.
  always_comb begin
    phase_next         = phase;
    crc_value_next     = crc_value;
    frame_length_next  = frame_length;
    bytes_seen_next    = bytes_seen;
    status_next        = STATUS_NONE;
    payload_valid_next = 1'b0;
    payload_byte_next  = '0;
    payload_index_next = '0;
    payload_last_next  = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (data_byte == header_value) begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        // The length byte is covered by the CRC; a zero length goes
        // straight to the CRC byte.
        crc_value_next    = crc_upd;
        frame_length_next = data_byte;
        bytes_seen_next   = '0;
        phase_next        = (data_byte == '0) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        crc_value_next     = crc_upd;
        payload_valid_next = 1'b1;
        payload_byte_next  = data_byte;
        payload_index_next = bytes_seen;
        bytes_seen_next    = seen_inc;
        if (seen_inc == frame_length) begin
          payload_last_next = 1'b1;
          phase_next        = PH_CRC;
        end
      end
      PH_CRC: begin
        // Whatever the check says, the frame state clears and the parser
        // looks for the next header.
        status_next       = (data_byte == crc_value) ? STATUS_GOOD : STATUS_CRC_ERR;
        phase_next        = PH_IDLE;
        crc_value_next    = '0;
        frame_length_next = '0;
        bytes_seen_next   = '0;
      end
      default: begin
        phase_next        = PH_IDLE;
        crc_value_next    = '0;
        frame_length_next = '0;
        bytes_seen_next   = '0;
      end
    endcase
  end

  // Frame state advances once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      crc_value    <= '0;
      frame_length <= '0;
      bytes_seen   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      crc_value    <= crc_value_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload; loads only with an accepted item, so it holds while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      payload_valid <= payload_valid_next;
      payload_byte  <= payload_byte_next;
      payload_index <= payload_index_next;
      payload_last  <= payload_last_next;
    end
  end

endmodule

### rtl/core/lfpp_checker.sv
// Port-level assertions for the packet parser, bound to the top level.
module lfpp_checker
  import lfpp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               header_we,
  input logic [ByteW-1:0]   header_wdata,
  input logic               data_valid,
  input logic               data_stall,
  input logic [ByteW-1:0]   data_byte,
  input logic               result_valid,
  input logic               result_stall,
  input logic [StatusW-1:0] status,
  input logic               payload_valid,
  input logic [ByteW-1:0]   payload_byte,
  input logic [ByteW-1:0]   payload_index,
  input logic               payload_last
);

  // The input side waits exactly when a held result is being stalled.
  a_stall_follows_result: assert property (@(posedge clk) disable iff (rst)
    data_stall == (result_valid && result_stall))
    else $error("input stall does not match the held result");

  // A last marker only comes with a payload byte.
  a_last_needs_payload: assert property (@(posedge clk) disable iff (rst)
    result_valid && payload_last |-> payload_valid)
    else $error("payload_last without payload_valid");

  // A frame ends on the CRC byte, never on a payload byte, and no unused code.
  a_status_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != STATUS_NONE |->
      !payload_valid && (status == STATUS_GOOD || status == STATUS_CRC_ERR))
    else $error("bad status or status on a payload byte");

  // A stalled result item stays in place.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status) &&
      $stable(payload_valid) && $stable(payload_byte) &&
      $stable(payload_index) && $stable(payload_last))
    else $error("stalled result item changed");

  // Unused inputs of the checker.
  logic unused_ok;
  assign unused_ok = header_we ^ (|header_wdata) ^ data_valid ^ (|data_byte);

endmodule

bind length_framed_packet_parser_crc8 lfpp_checker u_lfpp_checker (.*);
